### hdl/u8t_pkg.sv
`default_nettype none

package u8t_pkg;

	// Frame: start bit, eight data bits, stop bit.
	localparam int unsigned FRAME_BITS = 10;
	localparam int unsigned CFG_W = 16;
	localparam int unsigned CFG_IDX_W = 1;

	localparam logic [CFG_W-1:0] BIT_TICKS_RST = 16'd768;
	localparam logic [CFG_W-1:0] HALF_BIT_TICKS_RST = 16'd384;

	localparam logic [3:0] FRAME_BITS_C = 4'(FRAME_BITS);
	localparam logic [3:0] START_BIT_LEFT = 4'(FRAME_BITS - 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BIT_TICKS      = 1'b0,
		CFG_HALF_BIT_TICKS = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic       rx_level;
		logic       send_valid;
		logic [7:0] send_byte;
	} in_item_t;

	typedef struct packed {
		logic       tx_level;
		logic       send_accepted;
		logic       tx_active;
		logic       rx_active;
		logic       recv_valid;
		logic [7:0] recv_byte;
	} out_item_t;

endpackage

`default_nettype wire

### hdl/u8t_chan_if.sv
`default_nettype none

interface u8t_chan_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### hdl/uart_8n1_transceiver_core.sv
// 8N1 UART transceiver core, one transaction on the item channel per timer tick.
// Channels: "items" (sink) carries rx_level, send_valid and send_byte for one tick;
// "results" (source) carries tx_level, send_accepted, tx_active, rx_active,
// recv_valid and recv_byte after that tick. Every item yields exactly one result.
// Configuration: cfg_we/cfg_index/cfg_data write bit_ticks (index 0) and
// half_bit_ticks (index 1); write only while no tick is in flight.
// The result of a tick is registered and offered on "results" in the cycle after
// its transaction. Throughput: one tick per cycle while results drain; the tick
// counters and bit logic update combinationally from the registered state, and
// the result sits in a single output register. Items are taken whenever the output
// register is empty or is drained in the same cycle, so a stalled result stalls the
// item channel for exactly as long. Reset: transmitter and receiver idle, line
// levels at mark, counters cleared, bit_ticks = 768 and half_bit_ticks = 384.
`default_nettype none

module uart_8n1_transceiver_core
	import u8t_pkg::*;
#(
	parameter int unsigned TICK_WIDTH = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	u8t_chan_if.sink                  items,
	u8t_chan_if.source                results,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	typedef logic [TICK_WIDTH-1:0] tick_t;

	// Configuration registers.
	logic [CFG_W-1:0] bit_ticks_q;
	logic [CFG_W-1:0] half_bit_ticks_q;

	// Transmitter state.
	logic [8:0] tx_shift_q;
	logic [3:0] tx_bits_left_q;
	tick_t      tx_cnt_q;
	logic       tx_busy_q;
	logic       tx_out_q;

	// Receiver state.
	logic [9:0] rx_shift_q;
	logic [3:0] rx_bits_left_q;
	tick_t      rx_cnt_q;
	logic       rx_busy_q;
	logic       rx_prev_q;

	// Output register.
	logic      res_valid_s1;
	out_item_t res_s1;

	logic     fire;
	in_item_t itm;
	tick_t    bit_reload;
	tick_t    half_reload;

	logic [8:0] tx_shift_d;
	logic [3:0] tx_bits_left_d;
	tick_t      tx_cnt_d;
	logic       tx_busy_d;
	logic       tx_out_d;
	logic       accepted;

	logic [9:0] rx_shift_d;
	logic [3:0] rx_bits_left_d;
	tick_t      rx_cnt_d;
	logic       rx_busy_d;
	logic       rvalid;
	logic [7:0] rbyte;

	// Take a tick when the output register is empty or drains this cycle.
	assign items.ready = !res_valid_s1 || results.ready;
	assign fire        = items.valid && items.ready;
	assign itm         = items.data;

	// Truncate or zero-extend the 16-bit registers to the counter width.
	assign bit_reload  = TICK_WIDTH'(bit_ticks_q);
	assign half_reload = TICK_WIDTH'(half_bit_ticks_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_ticks_q      <= BIT_TICKS_RST;
			half_bit_ticks_q <= HALF_BIT_TICKS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_BIT_TICKS:      bit_ticks_q      <= cfg_data;
				CFG_HALF_BIT_TICKS: half_bit_ticks_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Transmitter: a bit event fires when the counter is at 0 or 1, then reloads.
	always_comb begin
		tx_shift_d     = tx_shift_q;
		tx_bits_left_d = tx_bits_left_q;
		tx_cnt_d       = tx_cnt_q;
		tx_busy_d      = tx_busy_q;
		tx_out_d       = tx_out_q;
		accepted       = 1'b0;
		if (tx_busy_q) begin
			if (tx_cnt_q[TICK_WIDTH-1:1] == '0) begin
				tx_cnt_d = bit_reload;
				if (tx_bits_left_q == 4'd0) begin
					// Stop bit begins: drive the line to mark and release busy.
					tx_out_d       = 1'b1;
					tx_busy_d      = 1'b0;
					tx_bits_left_d = FRAME_BITS_C;
				end else begin
					if (tx_bits_left_q == START_BIT_LEFT) begin
						tx_out_d = 1'b0;
					end else begin
						tx_out_d   = tx_shift_q[0];
						tx_shift_d = {1'b1, tx_shift_q[8:1]};
					end
					tx_bits_left_d = tx_bits_left_q - 4'd1;
				end
			end else begin
				tx_cnt_d = tx_cnt_q - tick_t'(1);
			end
		end else if (itm.send_valid) begin
			// Hold the line at mark for one bit time before the start bit.
			tx_shift_d     = {1'b1, itm.send_byte};
			tx_bits_left_d = START_BIT_LEFT;
			tx_cnt_d       = bit_reload;
			tx_busy_d      = 1'b1;
			accepted       = 1'b1;
		end
	end

	// Receiver: a falling edge while idle arms it; ten samples shift in from the top.
	always_comb begin
		rx_shift_d     = rx_shift_q;
		rx_bits_left_d = rx_bits_left_q;
		rx_cnt_d       = rx_cnt_q;
		rx_busy_d      = rx_busy_q;
		rvalid         = 1'b0;
		rbyte          = 8'd0;
		if (rx_busy_q) begin
			if (rx_cnt_q[TICK_WIDTH-1:1] == '0) begin
				rx_cnt_d       = bit_reload;
				rx_shift_d     = {itm.rx_level, rx_shift_q[9:1]};
				rx_bits_left_d = rx_bits_left_q - 4'd1;
				if (rx_bits_left_d == 4'd0) begin
					// Drop start and stop samples, keep the data byte.
					rvalid    = 1'b1;
					rbyte     = rx_shift_d[8:1];
					rx_busy_d = 1'b0;
				end
			end else begin
				rx_cnt_d = rx_cnt_q - tick_t'(1);
			end
		end else if (rx_prev_q && !itm.rx_level) begin
			rx_busy_d      = 1'b1;
			rx_shift_d     = '0;
			rx_bits_left_d = FRAME_BITS_C;
			rx_cnt_d       = half_reload;
		end
	end

	// Advance the state only on an accepted tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_shift_q     <= '1;
			tx_bits_left_q <= FRAME_BITS_C;
			tx_cnt_q       <= '0;
			tx_busy_q      <= 1'b0;
			tx_out_q       <= 1'b1;
			rx_shift_q     <= '0;
			rx_bits_left_q <= FRAME_BITS_C;
			rx_cnt_q       <= '0;
			rx_busy_q      <= 1'b0;
			rx_prev_q      <= 1'b1;
		end else if (fire) begin
			tx_shift_q     <= tx_shift_d;
			tx_bits_left_q <= tx_bits_left_d;
			tx_cnt_q       <= tx_cnt_d;
			tx_busy_q      <= tx_busy_d;
			tx_out_q       <= tx_out_d;
			rx_shift_q     <= rx_shift_d;
			rx_bits_left_q <= rx_bits_left_d;
			rx_cnt_q       <= rx_cnt_d;
			rx_busy_q      <= rx_busy_d;
			rx_prev_q      <= itm.rx_level;
		end
	end

	// Output register: load on an accepted tick, clear valid once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s1 <= 1'b0;
		end else if (fire) begin
			res_valid_s1 <= 1'b1;
		end else if (results.ready) begin
			res_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s1.tx_level      <= tx_out_d;
			res_s1.send_accepted <= accepted;
			res_s1.tx_active     <= tx_busy_d;
			res_s1.rx_active     <= rx_busy_d;
			res_s1.recv_valid    <= rvalid;
			res_s1.recv_byte     <= rbyte;
		end
	end

	assign results.valid = res_valid_s1;
	assign results.data  = res_s1;

endmodule

`default_nettype wire

### hdl/u8t_checker.sv
`default_nettype none

module u8t_checker
	import u8t_pkg::*;
(
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      in_valid,
	input wire logic      in_ready,
	input wire logic      out_valid,
	input wire logic      out_ready,
	input wire out_item_t out_data
);

	// A stalled result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// An empty output register never stalls the item channel.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("item channel stalled with empty output");

	// A taken byte starts a frame.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.send_accepted |-> out_data.tx_active)
		else $error("send accepted without transmitter busy");

	// A completed byte ends the receive frame, and the byte is zero otherwise.
	a_recv_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.recv_valid ? !out_data.rx_active
			: (out_data.recv_byte == 8'd0)))
		else $error("receive result inconsistent");

	// Each accepted item puts a result in the output register.
	a_item_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("accepted item gave no result");

endmodule

bind uart_8n1_transceiver_core u8t_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (items.valid),
	.in_ready  (items.ready),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.out_data  (results.data)
);

`default_nettype wire

### verif/uart_8n1_transceiver_core_tb.sv
`default_nettype none

module uart_8n1_transceiver_core_tb;
	import u8t_pkg::*;

	// Allow ten times the slowest legal run: about 560 ticks, each waiting out
	// the longest sender gap, the longest receiver stall and the output register.
	localparam int unsigned CYCLE_LIMIT = 250_000;
	localparam int unsigned GAP_MAX     = 18;

	// Per-tick line model: mirrors both halves of the transceiver, queues the
	// outputs each accepted tick must produce, and compares what comes back.
	class uart_tick_checker;
		logic [CFG_W-1:0] bit_ticks;
		logic [CFG_W-1:0] half_ticks;
		logic [8:0]       tx_shift;
		logic [3:0]       tx_left;
		logic [15:0]      tx_count;
		logic             tx_busy;
		logic             tx_line;
		logic [9:0]       rx_shift;
		logic [3:0]       rx_left;
		logic [15:0]      rx_count;
		logic             rx_busy;
		logic             rx_prev;
		out_item_t        expected_outputs[$];
		int unsigned      mismatches;
		int unsigned      strays;
		int unsigned      reports;
		int unsigned      checked;
		int unsigned      bytes_sent;
		int unsigned      bytes_heard;

		function new();
			bit_ticks   = BIT_TICKS_RST;
			half_ticks  = HALF_BIT_TICKS_RST;
			tx_shift    = '1;
			tx_left     = FRAME_BITS_C;
			tx_count    = '0;
			tx_busy     = 1'b0;
			tx_line     = 1'b1;
			rx_shift    = '0;
			rx_left     = FRAME_BITS_C;
			rx_count    = '0;
			rx_busy     = 1'b0;
			rx_prev     = 1'b1;
			mismatches  = 0;
			strays      = 0;
			reports     = 0;
			checked     = 0;
			bytes_sent  = 0;
			bytes_heard = 0;
		endfunction

		function void write_reg(cfg_idx_t idx, logic [CFG_W-1:0] value);
			case (idx)
				CFG_BIT_TICKS:      bit_ticks = value;
				CFG_HALF_BIT_TICKS: half_ticks = value;
				default: ;
			endcase
		endfunction

		// Count down one tick; a count of 0 or 1 fires the bit event and reloads.
		function bit boundary(inout logic [15:0] count, input logic [CFG_W-1:0] reload);
			if (count <= 16'd1) begin
				count = reload;
				return 1'b1;
			end
			count = count - 16'd1;
			return 1'b0;
		endfunction

		function void note_tick(in_item_t it);
			out_item_t o;
			o = '0;
			if (tx_busy) begin
				if (boundary(tx_count, bit_ticks)) begin
					if (tx_left == 4'd0) begin
						tx_line = 1'b1;
						tx_busy = 1'b0;
						tx_left = FRAME_BITS_C;
					end else begin
						if (tx_left == START_BIT_LEFT) begin
							tx_line = 1'b0;
						end else begin
							tx_line  = tx_shift[0];
							tx_shift = {1'b1, tx_shift[8:1]};
						end
						tx_left = tx_left - 4'd1;
					end
				end
			end else if (it.send_valid) begin
				tx_shift        = {1'b1, it.send_byte};
				tx_left         = START_BIT_LEFT;
				tx_count        = bit_ticks;
				tx_busy         = 1'b1;
				o.send_accepted = 1'b1;
				bytes_sent++;
			end

			if (rx_busy) begin
				if (boundary(rx_count, bit_ticks)) begin
					rx_shift = {it.rx_level, rx_shift[9:1]};
					rx_left  = rx_left - 4'd1;
					if (rx_left == 4'd0) begin
						o.recv_valid = 1'b1;
						o.recv_byte  = rx_shift[8:1];
						rx_busy      = 1'b0;
						bytes_heard++;
					end
				end
			end else if (rx_prev && !it.rx_level) begin
				rx_busy  = 1'b1;
				rx_shift = '0;
				rx_left  = FRAME_BITS_C;
				rx_count = half_ticks;
			end
			rx_prev = it.rx_level;

			o.tx_level  = tx_line;
			o.tx_active = tx_busy;
			o.rx_active = rx_busy;
			expected_outputs.push_back(o);
		endfunction

		function void check_outputs(out_item_t got);
			out_item_t want;
			bit        bad;
			if (expected_outputs.size() == 0) begin
				strays++;
				reports++;
				if (reports <= 10)
					$display("unexpected result: tx=%b acc=%b txa=%b rxa=%b rv=%b rb=%h",
						got.tx_level, got.send_accepted, got.tx_active,
						got.rx_active, got.recv_valid, got.recv_byte);
				return;
			end
			want = expected_outputs.pop_front();
			bad = (got.tx_level !== want.tx_level)
				|| (got.send_accepted !== want.send_accepted)
				|| (got.tx_active !== want.tx_active)
				|| (got.rx_active !== want.rx_active)
				|| (got.recv_valid !== want.recv_valid)
				|| (got.recv_byte !== want.recv_byte);
			if (bad) begin
				mismatches++;
				reports++;
				if (reports <= 10) begin
					$display("tick %0d: expected tx=%b acc=%b txa=%b rxa=%b rv=%b rb=%h",
						checked, want.tx_level, want.send_accepted, want.tx_active,
						want.rx_active, want.recv_valid, want.recv_byte);
					$display("tick %0d: got      tx=%b acc=%b txa=%b rxa=%b rv=%b rb=%h",
						checked, got.tx_level, got.send_accepted, got.tx_active,
						got.rx_active, got.recv_valid, got.recv_byte);
				end
			end
			checked++;
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	u8t_chan_if #(.T(in_item_t))  tick_ch ();
	u8t_chan_if #(.T(out_item_t)) res_ch ();

	uart_8n1_transceiver_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.items     (tick_ch),
		.results   (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	uart_tick_checker model;
	in_item_t         line_ticks[$];
	logic             rx_plan[$];
	int unsigned      cycles = 0;
	int unsigned      total_ticks;
	int unsigned      rate_settings;
	bit               send_calm;
	bit               drain_calm;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycles, model.expected_outputs.size());
			$display("FAIL");
			$finish;
		end
	end

	// Queue one hand-built tick.
	function automatic void push_tick(logic lvl, logic offer, logic [7:0] octet);
		in_item_t it;
		it.rx_level   = lvl;
		it.send_valid = offer;
		it.send_byte  = octet;
		line_ticks.push_back(it);
	endfunction

	// Append one stretch of receive line to rx_plan, `per` ticks per bit. Most are
	// clean frames after a random idle run; the rest carry a flipped tick, stop
	// short after a few data bits, or are plain noise.
	function automatic void add_line_frame(int unsigned per);
		logic [7:0]  octet;
		logic        line[$];
		int unsigned kind;
		int unsigned nbits;
		int unsigned flip;
		kind = $urandom_range(0, 9);
		repeat ($urandom_range(0, 2 * per)) rx_plan.push_back(1'b1);
		if (kind == 9) begin
			repeat ($urandom_range(1, 3 * per)) rx_plan.push_back(1'($urandom));
			return;
		end
		octet = 8'($urandom);
		nbits = (kind == 8) ? $urandom_range(0, 7) : 8;
		repeat (per) line.push_back(1'b0);
		for (int k = 0; k < nbits; k++)
			repeat (per) line.push_back(octet[k]);
		repeat (per) line.push_back(1'b1);
		if (kind == 7) begin
			flip = $urandom_range(0, line.size() - 1);
			line[flip] = !line[flip];
		end
		foreach (line[i]) rx_plan.push_back(line[i]);
	endfunction

	// Offer every queued tick, one transaction each, with a random hold-off
	// before each one; quiet stretches keep valid up back to back.
	task automatic drive_ticks();
		int unsigned gap;
		foreach (line_ticks[i]) begin
			if ($urandom_range(0, 24) == 0) send_calm = !send_calm;
			gap = send_calm ? 0 : $urandom_range(0, GAP_MAX);
			if (gap != 0) begin
				tick_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			tick_ch.valid <= 1'b1;
			tick_ch.data  <= line_ticks[i];
			do @(posedge clk); while (tick_ch.ready !== 1'b1);
			model.note_tick(line_ticks[i]);
			total_ticks++;
		end
		tick_ch.valid <= 1'b0;
		line_ticks.delete();
	endtask

	// Hold off until every result is back, then write both rate registers,
	// bit_ticks first.
	task automatic program_rates(logic [CFG_W-1:0] bt, logic [CFG_W-1:0] half);
		while (model.expected_outputs.size() != 0) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_BIT_TICKS;
		cfg_data  <= bt;
		@(posedge clk);
		cfg_index <= CFG_HALF_BIT_TICKS;
		cfg_data  <= half;
		@(posedge clk);
		cfg_we <= 1'b0;
		model.write_reg(CFG_BIT_TICKS, bt);
		model.write_reg(CFG_HALF_BIT_TICKS, half);
		rate_settings++;
	endtask

	// One random phase: program the rates, lay down receive frames at that
	// bit period, and offer bytes at the given percentage of ticks.
	task automatic run_phase(logic [CFG_W-1:0] bt, logic [CFG_W-1:0] half,
			int unsigned count, int unsigned offer_pct);
		in_item_t    it;
		int unsigned per;
		per = (bt == 0) ? 1 : int'(bt);
		program_rates(bt, half);
		rx_plan.delete();
		while (rx_plan.size() < count) add_line_frame(per);
		for (int i = 0; i < count; i++) begin
			it.rx_level   = rx_plan[i];
			it.send_valid = ($urandom_range(0, 99) < offer_pct);
			it.send_byte  = 8'($urandom);
			line_ticks.push_back(it);
		end
		drive_ticks();
	endtask

	// Result side: drop ready for a random number of cycles per result, then
	// hold it until a transaction lands and check it.
	initial begin
		int unsigned stall;
		drain_calm   = 1'b0;
		res_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 24) == 0) drain_calm = !drain_calm;
			stall = drain_calm ? 0 : $urandom_range(0, GAP_MAX);
			if (stall != 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (res_ch.valid !== 1'b1);
			model.check_outputs(res_ch.data);
		end
	end

	initial begin
		int unsigned failures;
		model         = new();
		total_ticks   = 0;
		rate_settings = 0;
		send_calm     = 1'b0;
		arst_n        <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_index     <= CFG_BIT_TICKS;
		cfg_data      <= '0;
		tick_ch.valid <= 1'b0;
		tick_ch.data  <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset rates: keep both lines at mark so no long count gets loaded.
		repeat (4) push_tick(1'b1, 1'b0, 8'($urandom));
		drive_ticks();

		// Zero rates behave like one tick per bit. Offer on most ticks: the first
		// byte goes, offers while busy and on the tick busy clears are refused,
		// the next one is taken right after. The receive frame carries 0xff and
		// a low stop sample, so a falling edge lands on the completing tick and
		// must not arm; a later edge does.
		program_rates('0, '0);
		push_tick(1'b1, 1'b1, 8'h00);
		push_tick(1'b0, 1'b1, 8'hff);
		push_tick(1'b0, 1'b1, 8'haa);
		repeat (8) push_tick(1'b1, 1'b1, 8'($urandom));
		push_tick(1'b0, 1'b1, 8'hff);
		push_tick(1'b0, 1'b1, 8'h55);
		push_tick(1'b1, 1'b0, 8'h00);
		push_tick(1'b0, 1'b1, 8'h81);
		push_tick(1'b0, 1'b0, 8'hff);
		drive_ticks();

		// Random phases: shortest legal period, centered and late sampling,
		// half period equal to the bit period (edge on the completing tick),
		// sampling past the next start, and the degenerate one-tick period.
		run_phase(16'd2, 16'd1, 90, 50);
		run_phase(16'd3, 16'd1, 90, 30);
		run_phase(16'd4, 16'd2, 80, 20);
		run_phase(16'd3, 16'd3, 80, 40);
		run_phase(16'd5, 16'd7, 80, 25);
		run_phase(16'd1, 16'd0, 50, 60);
		run_phase(16'd6, 16'd3, 60, 35);

		// Widest rates last: arm both halves with full-scale counts.
		program_rates('1, '1);
		push_tick(1'b1, 1'b1, 8'hff);
		push_tick(1'b0, 1'b1, 8'h00);
		push_tick(1'b1, 1'b0, 8'h7e);
		push_tick(1'b0, 1'b1, 8'h01);
		repeat (4) push_tick(1'(1'($urandom)), 1'(1'($urandom)), 8'($urandom));
		drive_ticks();

		// Drain, then give the output register a few extra edges for strays.
		while (model.expected_outputs.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		failures = model.mismatches + model.strays + model.expected_outputs.size();
		$display("ran %0d ticks over %0d rate settings: %0d bytes sent, %0d bytes received",
			total_ticks, rate_settings, model.bytes_sent, model.bytes_heard);
		$display("%0d results checked, %0d mismatched, %0d unexpected, %0d missing",
			model.checked, model.mismatches, model.strays, model.expected_outputs.size());
		if (failures == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

`default_nettype wire
